// File: sv/jsl_pkg.sv
package jsl_pkg;

    localparam int NUM_JOINTS = 6;
    localparam int POS_WIDTH  = 32;

    localparam int SLEW_W     = 16;
    localparam int TICK_W     = 25;
    localparam int VEL_W      = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 3;
    localparam int RUN_W      = 32;
    localparam int SUM_W      = 48;
    localparam int Q_DEPTH    = 2;
    localparam int NUM_REGS   = 2 + NUM_JOINTS;

    localparam logic [CFG_IDX_W-1:0] REG_SLEW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TICK = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_VEL0 = CFG_IDX_W'(2);

    localparam logic [SLEW_W-1:0] SLEW_RESET = SLEW_W'(16384);
    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(67109);

    localparam logic CMD_LIMIT  = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    // queue entry kinds, decided by the front end
    localparam logic [1:0] KIND_LIMIT  = 2'd0;
    localparam logic [1:0] KIND_PASS   = 2'd1;
    localparam logic [1:0] KIND_RESEED = 2'd2;

    typedef logic [NUM_JOINTS-1:0][POS_WIDTH-1:0] t_pos_vec;

    typedef struct packed {
        logic [1:0] kind;
        t_pos_vec   pos;
    } t_qent;

    typedef struct packed {
        logic                   not_empty;
        logic                   full;
    } t_q_stat;

    typedef struct packed {
        logic                   cmd;
        logic signed [POS_WIDTH-1:0] joint_pos_0;
        logic signed [POS_WIDTH-1:0] joint_pos_1;
        logic signed [POS_WIDTH-1:0] joint_pos_2;
        logic signed [POS_WIDTH-1:0] joint_pos_3;
        logic signed [POS_WIDTH-1:0] joint_pos_4;
        logic signed [POS_WIDTH-1:0] joint_pos_5;
    } t_in;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] out_pos_0;
        logic signed [POS_WIDTH-1:0] out_pos_1;
        logic signed [POS_WIDTH-1:0] out_pos_2;
        logic signed [POS_WIDTH-1:0] out_pos_3;
        logic signed [POS_WIDTH-1:0] out_pos_4;
        logic signed [POS_WIDTH-1:0] out_pos_5;
        logic [CNT_W-1:0]       clipped_count;
        logic [RUN_W-1:0]       run_of_clipped_ticks;
        logic [SUM_W-1:0]       clip_total;
    } t_out;

endpackage

// File: sv/joint_slew_limiter_unit.sv
// Joint slew limiter: six-joint position commands in, limited positions out.
// Input channel (i_in_valid / o_in_stall, payload i_in) takes one beat per
// cycle while o_in_stall is low. cmd = limit clamps each joint to within its step
// of the reference (previous output or reseed position) and yields one output beat;
// cmd = reseed loads the reference, clears the clipped-tick run and yields no beat.
// The first beat accepted after reset, if a limit, passes through unclipped.
// Output channel (o_out_valid / i_out_stall, payload o_out) is a register.
// An accepted beat is registered in the queue and then in the output register;
// throughput is one beat per cycle when nothing stalls, set by the combinational clamp lanes in the back end.
// Step limits (slew scale * velocity limit * tick period) come from a sequencer
// with one 16x32 and one shared 24x25 multiplier, in phases A, HI, LO and SUM for
// each joint in turn. The sweep runs after reset and after every config write
// (i_cfg_we / i_cfg_idx / i_cfg_data); o_in_stall stays high meanwhile.
// Synchronous active-low reset clears counters, queue and reference-seen flag, not the reference.
// While the receiver stalls, the output beat holds; a two-entry queue soaks
// up two more beats (reseeds drain regardless) before o_in_stall rises.
module joint_slew_limiter_unit
    import jsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic     step_busy;
    t_pos_vec step;
    t_q_stat  q_stat;
    logic     q_push;
    logic     q_pop;
    t_qent    q_in;
    t_qent    q_out;

    jsl_step_calc u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (step_busy),
        .o_step     (step)
    );

    jsl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_step_busy (step_busy),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_ent       (q_in)
    );

    jsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .i_pop   (q_pop),
        .o_ent   (q_out),
        .o_stat  (q_stat)
    );

    jsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ent       (q_out),
        .i_q_stat    (q_stat),
        .i_step      (step),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_cfg_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> step_busy)
        else $error("config write did not start step recompute");

    a_run_follows_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.clipped_count != '0)) |-> (o_out.run_of_clipped_ticks != '0))
        else $error("clipped beat with zero clip run");

    a_clip_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.clipped_count <= CNT_W'(NUM_JOINTS)))
        else $error("clipped count exceeds joint count");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");
`endif

endmodule

// File: sv/jsl_step_calc.sv
module jsl_step_calc
    import jsl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output t_pos_vec              o_step
);

    localparam int JW     = $clog2(NUM_JOINTS);
    localparam int A_W    = SLEW_W + VEL_W;
    localparam int SPLIT  = 24;
    localparam int HI_W   = A_W - SPLIT;
    localparam int P_W    = HI_W + TICK_W;
    localparam int S_W    = P_W + 1;
    localparam int SHIFT  = 14;

    localparam logic [1:0] PH_A   = 2'd0;
    localparam logic [1:0] PH_HI  = 2'd1;
    localparam logic [1:0] PH_LO  = 2'd2;
    localparam logic [1:0] PH_SUM = 2'd3;

    logic [SLEW_W-1:0] r_slew;
    logic [TICK_W-1:0] r_tick;
    logic [VEL_W-1:0]  r_vel [NUM_JOINTS];
    logic              r_busy;
    logic [JW-1:0]     r_jn;
    logic [1:0]        r_ph;
    logic [A_W-1:0]    r_a;
    logic [P_W-1:0]    r_hi;
    logic [P_W-1:0]    r_lo;
    t_pos_vec          r_step;

    logic [CFG_IDX_W-1:0] vel_off;
    logic                 vel_hit;
    logic [HI_W-1:0]      mul_op;
    logic [P_W-1:0]       mul_prod;
    logic [S_W-1:0]       sum_full;
    logic [POS_WIDTH-1:0] step_sat;

    assign vel_off = i_cfg_idx - REG_VEL0;
    assign vel_hit = (i_cfg_idx >= REG_VEL0) && (i_cfg_idx < CFG_IDX_W'(NUM_REGS));

    // one shared 24x25 multiplier for both halves of slew*vel
    assign mul_op   = (r_ph == PH_HI) ? r_a[A_W-1:SPLIT] : HI_W'(r_a[SPLIT-1:0]);
    assign mul_prod = P_W'(mul_op) * P_W'(r_tick);

    assign sum_full = {1'b0, r_hi} + S_W'(r_lo >> SPLIT);

    always_comb begin
        if (|sum_full[S_W-1:SHIFT+POS_WIDTH]) begin
            step_sat = '1;
        end else begin
            step_sat = sum_full[SHIFT+POS_WIDTH-1:SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew <= SLEW_RESET;
            r_tick <= TICK_RESET;
            for (int k = 0; k < NUM_JOINTS; k++) begin
                r_vel[k] <= '0;
            end
            r_busy <= 1'b1;
            r_jn   <= '0;
            r_ph   <= PH_A;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_SLEW) begin
                r_slew <= i_cfg_data[SLEW_W-1:0];
            end else if (i_cfg_idx == REG_TICK) begin
                r_tick <= i_cfg_data[TICK_W-1:0];
            end else if (vel_hit) begin
                r_vel[vel_off[JW-1:0]] <= i_cfg_data[VEL_W-1:0];
            end
            // restart the sweep; an ignored write just recomputes the same values
            r_busy <= 1'b1;
            r_jn   <= '0;
            r_ph   <= PH_A;
        end else if (r_busy) begin
            case (r_ph)
                PH_A: begin
                    r_a  <= A_W'(r_slew) * A_W'(r_vel[r_jn]);
                    r_ph <= PH_HI;
                end
                PH_HI: begin
                    r_hi <= mul_prod;
                    r_ph <= PH_LO;
                end
                PH_LO: begin
                    r_lo <= mul_prod;
                    r_ph <= PH_SUM;
                end
                PH_SUM: begin
                    r_step[r_jn] <= step_sat;
                    r_ph         <= PH_A;
                    if (r_jn == JW'(NUM_JOINTS - 1)) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_jn <= r_jn + JW'(1);
                    end
                end
                default: begin
                    r_ph <= PH_A;
                end
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_step = r_step;

endmodule

// File: sv/jsl_front.sv
module jsl_front
    import jsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in     i_in,
    input  logic    i_step_busy,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_qent   o_ent
);

    logic r_ref_seen;
    logic accept;

    assign o_in_stall = i_step_busy | i_q_stat.full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = accept;

    always_comb begin
        o_ent.pos[0] = i_in.joint_pos_0;
        o_ent.pos[1] = i_in.joint_pos_1;
        o_ent.pos[2] = i_in.joint_pos_2;
        o_ent.pos[3] = i_in.joint_pos_3;
        o_ent.pos[4] = i_in.joint_pos_4;
        o_ent.pos[5] = i_in.joint_pos_5;
        if (i_in.cmd == CMD_RESEED) begin
            o_ent.kind = KIND_RESEED;
        end else if (!r_ref_seen) begin
            o_ent.kind = KIND_PASS;
        end else begin
            o_ent.kind = KIND_LIMIT;
        end
    end

    // any beat, reseed or limit, leaves a reference behind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_seen <= 1'b0;
        end else if (accept) begin
            r_ref_seen <= 1'b1;
        end
    end

endmodule

// File: sv/jsl_queue.sv
module jsl_queue
    import jsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qent   i_ent,
    input  logic    i_pop,
    output t_qent   o_ent,
    output t_q_stat o_stat
);

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_qent         r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_cnt != CW'(Q_DEPTH));
    assign do_pop  = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    assign o_ent            = r_mem[r_rp];
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.full      = (r_cnt == CW'(Q_DEPTH));

endmodule

// File: sv/jsl_back.sv
module jsl_back
    import jsl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_qent    i_ent,
    input  t_q_stat  i_q_stat,
    input  t_pos_vec i_step,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out     o_out
);

    localparam int EW = POS_WIDTH + 2;
    localparam logic signed [EW-1:0] PMAX = {3'b000, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [EW-1:0] PMIN = {3'b111, {(POS_WIDTH-1){1'b0}}};

    t_pos_vec         r_ref;
    logic [RUN_W-1:0] r_run;
    logic [SUM_W-1:0] r_sum;
    logic             r_out_valid;
    t_out             r_out;

    t_pos_vec              lim;
    t_pos_vec              res;
    logic [NUM_JOINTS-1:0] clip;
    logic [CNT_W-1:0]      cnt;
    logic [RUN_W-1:0]      run_next;
    logic [SUM_W:0]        sum_ext;
    logic [SUM_W-1:0]      sum_next;
    logic                  out_free;
    logic                  emit;

    assign out_free = ~r_out_valid | ~i_out_stall;
    assign o_pop    = i_q_stat.not_empty & ((i_ent.kind == KIND_RESEED) | out_free);
    assign emit     = o_pop & (i_ent.kind != KIND_RESEED);

    // per-joint clamp against the reference (last output or reseed), lanes are independent
    always_comb begin
        logic signed [EW-1:0] want_x;
        logic signed [EW-1:0] prev_x;
        logic signed [EW-1:0] step_x;
        logic signed [EW-1:0] up;
        logic signed [EW-1:0] dn;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            want_x = {{2{i_ent.pos[j][POS_WIDTH-1]}}, i_ent.pos[j]};
            prev_x = {{2{r_ref[j][POS_WIDTH-1]}}, r_ref[j]};
            step_x = {2'b00, i_step[j]};
            up     = prev_x + step_x;
            dn     = prev_x - step_x;
            if (want_x > up) begin
                clip[j] = 1'b1;
                lim[j]  = (up > PMAX) ? PMAX[POS_WIDTH-1:0] : up[POS_WIDTH-1:0];
            end else if (want_x < dn) begin
                clip[j] = 1'b1;
                lim[j]  = (dn < PMIN) ? PMIN[POS_WIDTH-1:0] : dn[POS_WIDTH-1:0];
            end else begin
                clip[j] = 1'b0;
                lim[j]  = i_ent.pos[j];
            end
        end
    end

    always_comb begin
        if (i_ent.kind == KIND_LIMIT) begin
            res = lim;
            cnt = CNT_W'($countones(clip));
        end else begin
            res = i_ent.pos;
            cnt = '0;
        end
        if (cnt == '0) begin
            run_next = '0;
        end else if (r_run == '1) begin
            run_next = r_run;
        end else begin
            run_next = r_run + RUN_W'(1);
        end
        sum_ext  = {1'b0, r_sum} + (SUM_W+1)'(cnt);
        sum_next = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                case (i_ent.kind)
                    KIND_RESEED: begin
                        r_run <= '0;
                    end
                    KIND_LIMIT: begin
                        r_run <= run_next;
                        r_sum <= sum_next;
                    end
                    default: begin
                    end
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ref <= res;
        end
        if (emit) begin
            r_out.out_pos_0     <= res[0];
            r_out.out_pos_1     <= res[1];
            r_out.out_pos_2     <= res[2];
            r_out.out_pos_3     <= res[3];
            r_out.out_pos_4     <= res[4];
            r_out.out_pos_5     <= res[5];
            r_out.clipped_count <= cnt;
            if (i_ent.kind == KIND_LIMIT) begin
                r_out.run_of_clipped_ticks <= run_next;
                r_out.clip_total           <= sum_next;
            end else begin
                r_out.run_of_clipped_ticks <= r_run;
                r_out.clip_total           <= r_sum;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
